@@ design/lmfg_pkg.sv @@
// Shared types, register indexes and arithmetic helpers of the LED frame generator.
package lmfg_pkg;

    localparam logic [1:0] FUNC_SET = 2'd0;
    localparam logic [1:0] FUNC_GET = 2'd1;
    localparam logic [1:0] FUNC_UPD = 2'd2;

    localparam logic [2:0] REG_FULL_LEVEL  = 3'd0;
    localparam logic [2:0] REG_PING_LEVEL  = 3'd1;
    localparam logic [2:0] REG_FLASH_PER   = 3'd2;
    localparam logic [2:0] REG_FLASH_ON    = 3'd3;
    localparam logic [2:0] REG_PING_PER    = 3'd4;
    localparam logic [2:0] REG_PING_ON     = 3'd5;
    localparam logic [2:0] REG_ONCE_TICKS  = 3'd6;
    localparam logic [2:0] REG_SWING_STEP  = 3'd7;

    localparam logic [2:0] COLOR_OFF   = 3'd0;
    localparam logic [2:0] COLOR_RED   = 3'd1;
    localparam logic [2:0] COLOR_GREEN = 3'd2;
    localparam logic [2:0] COLOR_BLUE  = 3'd3;
    localparam logic [2:0] COLOR_WHITE = 3'd4;

    localparam logic [2:0] MODE_FLASH = 3'd1;
    localparam logic [2:0] MODE_SWING = 3'd2;
    localparam logic [2:0] MODE_PING  = 3'd3;
    localparam logic [2:0] MODE_ONCE  = 3'd4;

    localparam logic [7:0] QUARTER_SINE [65] = '{
        8'd0, 8'd3, 8'd6, 8'd9, 8'd13, 8'd16, 8'd19, 8'd22,
        8'd25, 8'd28, 8'd31, 8'd34, 8'd37, 8'd40, 8'd43, 8'd46,
        8'd49, 8'd52, 8'd55, 8'd58, 8'd60, 8'd63, 8'd66, 8'd68,
        8'd71, 8'd74, 8'd76, 8'd79, 8'd81, 8'd84, 8'd86, 8'd88,
        8'd91, 8'd93, 8'd95, 8'd97, 8'd99, 8'd101, 8'd103, 8'd105,
        8'd106, 8'd108, 8'd110, 8'd111, 8'd113, 8'd114, 8'd116, 8'd117,
        8'd118, 8'd119, 8'd121, 8'd122, 8'd122, 8'd123, 8'd124, 8'd125,
        8'd126, 8'd126, 8'd127, 8'd127, 8'd127, 8'd128, 8'd128, 8'd128,
        8'd128
    };

    typedef struct packed {
        logic [2:0]  color;
        logic [2:0]  mode;
        logic [7:0]  once;
        logic [23:0] last;
        logic [23:0] pend;
    } t_cell_state;

    typedef struct packed {
        logic       we;
        logic [2:0] idx;
        logic [2:0] color;
        logic [2:0] mode;
        logic [7:0] once;
    } t_set_cmd;

    // Gain 128 + 128*sin, Q2.7, from an 8-bit phase.
    function automatic logic [8:0] lmfg_gain(input logic [7:0] p);
        logic [6:0] k;
        logic [8:0] s;
        k = {1'b0, p[5:0]};
        case (p[7:6])
            2'd0:    s = {1'b0, QUARTER_SINE[k]};
            2'd1:    s = {1'b0, QUARTER_SINE[7'd64 - k]};
            2'd2:    s = {1'b0, QUARTER_SINE[k]};
            default: s = {1'b0, QUARTER_SINE[7'd64 - k]};
        endcase
        return p[7] ? (9'd128 - s) : (9'd128 + s);
    endfunction

    function automatic logic [7:0] lmfg_scale(input logic [7:0] c, input logic [8:0] g);
        logic [16:0] v;
        v = {9'd0, c} * {8'd0, g};
        return (v[16:7] > 10'd255) ? 8'hFF : v[14:7];
    endfunction

endpackage

@@ design/lmfg_cell.sv @@
// One LED cell of the ring: stored color, mode, countdown and frame words.
module lmfg_cell import lmfg_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_shift,
    input  t_cell_state i_d,
    input  t_set_cmd    i_set,
    output t_cell_state o_q
);

    t_cell_state r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end else if (i_set.we && (int'(i_set.idx) == CELL_IDX)) begin
            r_q.color <= i_set.color;
            r_q.mode  <= i_set.mode;
            if (i_set.mode == MODE_ONCE) begin
                r_q.once <= i_set.once;
            end
        end
    end

    assign o_q = r_q;

endmodule

@@ design/lmfg_mod.sv @@
// Restoring remainder unit: 32-bit time modulo a 16-bit period, one bit per cycle.
module lmfg_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_busy,
    output logic [15:0] o_rem
);

    logic [31:0] r_num;
    logic [15:0] r_den;
    logic [15:0] r_rem;
    logic [5:0]  r_cnt;
    logic [16:0] w_try;
    logic [16:0] w_sub;

    assign w_try = {r_rem, r_num[31]};
    assign w_sub = w_try - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_cnt != 6'd0) begin
            r_num <= {r_num[30:0], 1'b0};
            r_rem <= (w_try >= {1'b0, r_den}) ? w_sub[15:0] : w_try[15:0];
        end
    end

    assign o_busy = (r_cnt != 6'd0);
    assign o_rem  = r_rem;

endmodule

@@ design/led_mode_frame_generator.sv @@
// LED mode frame generator: per-LED color/mode ring and byte stream output.
//
// Input channel (i_in_valid / o_in_stall): func 0 sets an LED's color and
// mode, func 1 gets its color, func 2 updates the frame at time i_now_ms.
// Output channel (o_out_valid / i_out_stall): one byte per item, either a
// get reply (o_out_kind = 1) or LED data in green, red, blue order.
// A set is taken in the controller's idle state; a get goes through the
// reply state, which puts the reply byte in the output register. An update
// first runs the bit-serial modulo units for the flash and ping windows,
// then a scan in which the cell ring rotates once past the frame logic,
// then, if any LED changed, 3*LED_COUNT bytes at one per cycle while the
// output is not stalled, as the ring rotates a second time past the head.
// The input is stalled while an item is in work; a stalled output holds
// its byte and the emit sequence waits. Reset clears all LEDs to off and
// stable, the last-sent frame to zero, and loads register defaults.
// Configuration writes through i_cfg_we / i_cfg_idx / i_cfg_data.
module led_mode_frame_generator import lmfg_pkg::*; #(
    parameter int LED_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [2:0]  i_led_index,
    input  logic [2:0]  i_color_code,
    input  logic [2:0]  i_mode_code,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_is_last
);

    localparam int STEP_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LED_COUNT - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CALC  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_EMIT  = 5'b01000,
        S_REPLY = 5'b10000
    } t_state;

    t_state r_state;

    logic [7:0]  r_full_level, r_ping_level, r_once_ticks;
    logic [15:0] r_flash_per, r_flash_on, r_ping_per, r_ping_on, r_swing_step;

    logic [31:0] r_now;
    logic [7:0]  r_phase;
    logic        r_flash_win, r_ping_win, r_changed;
    logic [STEP_W-1:0] r_step;
    logic [1:0]  r_byte;
    logic [2:0]  r_reply;

    logic        r_out_valid, r_out_kind, r_out_last;
    logic [7:0]  r_out_byte;

    logic        w_accept, w_shift, w_out_free, w_start, w_load;
    logic        w_flash_busy, w_ping_busy;
    logic [15:0] w_flash_rem, w_ping_rem;
    logic [47:0] w_prod;
    logic [8:0]  w_gain;
    logic [7:0]  w_ch_r, w_ch_g, w_ch_b;
    logic [23:0] w_frame;
    logic [2:0]  w_get_color;
    t_cell_state w_fb;
    t_set_cmd    w_set;
    t_cell_state w_q [LED_COUNT];

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_start    = w_accept && (i_func == FUNC_UPD);
    assign w_prod     = {16'd0, i_now_ms} * {32'd0, r_swing_step};
    assign w_load     = w_out_free && ((r_state == S_EMIT) || (r_state == S_REPLY));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_level <= 8'd25;
            r_ping_level <= 8'd25;
            r_flash_per  <= 16'd500;
            r_flash_on   <= 16'd250;
            r_ping_per   <= 16'd1000;
            r_ping_on    <= 16'd100;
            r_once_ticks <= 8'd100;
            r_swing_step <= 16'd8500;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FULL_LEVEL: r_full_level <= i_cfg_data[7:0];
                REG_PING_LEVEL: r_ping_level <= i_cfg_data[7:0];
                REG_FLASH_PER:  r_flash_per  <= i_cfg_data;
                REG_FLASH_ON:   r_flash_on   <= i_cfg_data;
                REG_PING_PER:   r_ping_per   <= i_cfg_data;
                REG_PING_ON:    r_ping_on    <= i_cfg_data;
                REG_ONCE_TICKS: r_once_ticks <= i_cfg_data[7:0];
                REG_SWING_STEP: r_swing_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lmfg_mod u_flash_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (i_now_ms),
        .i_den   (r_flash_per),
        .o_busy  (w_flash_busy),
        .o_rem   (w_flash_rem)
    );

    lmfg_mod u_ping_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (i_now_ms),
        .i_den   (r_ping_per),
        .o_busy  (w_ping_busy),
        .o_rem   (w_ping_rem)
    );

    assign w_set.we    = w_accept && (i_func == FUNC_SET);
    assign w_set.idx   = i_led_index;
    assign w_set.color = i_color_code;
    assign w_set.mode  = i_mode_code;
    assign w_set.once  = r_once_ticks;

    // Ring of cells: each takes its upper neighbor, the top takes the feedback.
    for (genvar k = 0; k < LED_COUNT; k++) begin : g_cell
        t_cell_state w_d;
        if (k == LED_COUNT - 1) begin : g_top
            assign w_d = w_fb;
        end else begin : g_mid
            assign w_d = w_q[k+1];
        end
        lmfg_cell #(.CELL_IDX(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_d     (w_d),
            .i_set   (w_set),
            .o_q     (w_q[k])
        );
    end

    always_comb begin
        w_get_color = COLOR_OFF;
        for (int k = 0; k < LED_COUNT; k++) begin
            if (int'(i_led_index) == k) begin
                w_get_color = w_q[k].color;
            end
        end
    end

    // Frame rule for the LED at the head of the ring.
    assign w_gain = lmfg_gain(r_phase);

    always_comb begin
        logic [2:0] code;
        code   = w_q[0].color;
        w_ch_r = (code == COLOR_RED   || code == COLOR_WHITE) ? r_full_level : 8'd0;
        w_ch_g = (code == COLOR_GREEN || code == COLOR_WHITE) ? r_full_level : 8'd0;
        w_ch_b = (code == COLOR_BLUE  || code == COLOR_WHITE) ? r_full_level : 8'd0;
        w_fb   = w_q[0];
        case (w_q[0].mode)
            MODE_FLASH: begin
                if (!r_flash_win) begin
                    w_ch_r = 8'd0;
                    w_ch_g = 8'd0;
                    w_ch_b = 8'd0;
                end
            end
            MODE_SWING: begin
                w_ch_r = lmfg_scale(w_ch_r, w_gain);
                w_ch_g = lmfg_scale(w_ch_g, w_gain);
                w_ch_b = lmfg_scale(w_ch_b, w_gain);
            end
            MODE_PING: begin
                w_ch_r = (w_ch_r != 8'd0 && r_ping_win) ? r_ping_level : 8'd0;
                w_ch_g = (w_ch_g != 8'd0 && r_ping_win) ? r_ping_level : 8'd0;
                w_ch_b = (w_ch_b != 8'd0 && r_ping_win) ? r_ping_level : 8'd0;
            end
            MODE_ONCE: begin
                if (w_q[0].once != 8'd0) begin
                    w_ch_r = lmfg_scale(w_ch_r, w_gain);
                    w_ch_g = lmfg_scale(w_ch_g, w_gain);
                    w_ch_b = lmfg_scale(w_ch_b, w_gain);
                    if (r_state == S_SCAN) begin
                        w_fb.once = w_q[0].once - 8'd1;
                    end
                end else if (r_state == S_SCAN) begin
                    w_fb.color = COLOR_OFF;
                end
            end
            default: ;
        endcase
        w_frame = {w_ch_r, w_ch_g, w_ch_b};
        if (r_state == S_SCAN) begin
            w_fb.pend = w_frame;
        end else begin
            w_fb.last = w_q[0].pend;
        end
    end

    assign w_shift = (r_state == S_SCAN) ||
                     ((r_state == S_EMIT) && w_out_free && (r_byte == 2'd2));

    // Controller.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_byte      <= '0;
            r_changed   <= 1'b0;
        end else begin
            // drop a taken item unless a new one loads in this cycle
            if (r_out_valid && !i_out_stall && !w_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_now   <= i_now_ms;
                        r_phase <= w_prod[23:16];
                        r_reply <= w_get_color;
                        if (i_func == FUNC_GET) begin
                            r_state <= S_REPLY;
                        end else if (i_func == FUNC_UPD) begin
                            r_state <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    if (!w_flash_busy && !w_ping_busy) begin
                        r_flash_win <= (r_flash_per == 16'd0) ?
                            (r_now < {16'd0, r_flash_on}) : (w_flash_rem < r_flash_on);
                        r_ping_win  <= (r_ping_per == 16'd0) ?
                            (r_now < {16'd0, r_ping_on}) : (w_ping_rem < r_ping_on);
                        r_step    <= '0;
                        r_changed <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_changed <= r_changed || (w_frame != w_q[0].last);
                    if (r_step == LAST_STEP) begin
                        r_step <= '0;
                        r_byte <= '0;
                        r_state <= (r_changed || (w_frame != w_q[0].last)) ? S_EMIT : S_IDLE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= 1'b0;
                        r_out_last  <= (r_step == LAST_STEP) && (r_byte == 2'd2);
                        case (r_byte)
                            2'd0:    r_out_byte <= w_q[0].pend[15:8];
                            2'd1:    r_out_byte <= w_q[0].pend[23:16];
                            default: r_out_byte <= w_q[0].pend[7:0];
                        endcase
                        if (r_byte == 2'd2) begin
                            r_byte <= '0;
                            if (r_step == LAST_STEP) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_step <= r_step + 1'b1;
                            end
                        end else begin
                            r_byte <= r_byte + 2'd1;
                        end
                    end
                end
                S_REPLY: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= 1'b1;
                        r_out_last  <= 1'b1;
                        r_out_byte  <= {5'd0, r_reply};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_byte  = r_out_byte;
    assign o_is_last   = r_out_last;

endmodule

@@ design/lmfg_checker.sv @@
// Port-level checks of the LED frame generator, bound to the top level.
module lmfg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_out_kind,
    input logic [7:0] o_out_byte,
    input logic       o_is_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte))
        else $error("stalled output item changed");

    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind |-> o_is_last)
        else $error("get reply not marked last");

    a_reply_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind |-> o_out_byte[7:3] == 5'd0)
        else $error("get reply code out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

endmodule

bind led_mode_frame_generator lmfg_checker u_lmfg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_kind  (o_out_kind),
    .o_out_byte  (o_out_byte),
    .o_is_last   (o_is_last)
);
